### rtl/skt_pkg.sv
`timescale 1ns / 1ps
package skt_pkg;
   localparam int Depth = 256;
   localparam int IndexWidth = 8;
   localparam int CountWidth = 9;
   localparam int KeyWidth = 32;
   localparam int PayloadWidth = 32;

   localparam logic [2:0] OP_INSERT     = 3'd0;
   localparam logic [2:0] OP_DELETE     = 3'd1;
   localparam logic [2:0] OP_FIND       = 3'd2;
   localparam logic [2:0] OP_FIND_FIRST = 3'd3;
   localparam logic [2:0] OP_READ       = 3'd4;
   localparam logic [2:0] OP_CLEAR      = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_BAD_INDEX = 2'd3;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] key;
      logic [31:0] payload;
      logic [7:0]  index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  found_index;
      logic [31:0] found_key;
      logic [31:0] found_payload;
      logic [8:0]  entry_total;
   } rsp_type;

   typedef struct packed {
      logic [KeyWidth-1:0]     key;
      logic [PayloadWidth-1:0] payload;
   } entry_type;
endpackage

### rtl/skt_ram.sv
`timescale 1ns / 1ps
module skt_ram #(
   parameter int Words = 256,
   parameter int Width = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Words)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Words)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Words];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/sorted_key_table.sv
`timescale 1ns / 1ps
// Sorted key table of 256 entries in one single-port-read, single-port-write RAM.
// Insert scans upward for its place and then shifts later entries up; delete
// shifts later entries down; find is a binary search; find-first then steps
// down over each equal entry; read passes through S_READ and S_DONE to the
// registered result. Operations run one at a time on the one RAM read port, and
// no new request is taken while busy. busy is high while an operation runs; the
// result strobe rsp_valid lasts one cycle and cannot be stalled.
module sorted_key_table
   import skt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_SHIFT  = 3'd2;
   localparam logic [2:0] S_SEARCH = 3'd3;
   localparam logic [2:0] S_WALK   = 3'd4;
   localparam logic [2:0] S_READ   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic                  phase_ff, phase_in;
   logic [CountWidth-1:0] count_ff, count_in;
   req_type               req_ff, req_in;
   logic [CountWidth-1:0] pos_ff, pos_in;
   logic [CountWidth:0]   first_ff, first_in, last_ff, last_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  valid_ff, valid_in;
   entry_type             hold_ff, hold_in;

   logic                  wr_en;
   logic [IndexWidth-1:0] wr_addr, rd_addr;
   entry_type             wr_data, rd_data;
   logic [CountWidth:0]   mid;

   skt_ram #(.Words(Depth), .Width(KeyWidth + PayloadWidth)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign mid = (first_ff + last_ff) >> 1;
   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; count_in = count_ff;
      req_in = req_ff; pos_in = pos_ff; first_in = first_ff; last_in = last_ff;
      rsp_in = rsp_ff; valid_in = 1'b0; hold_in = hold_ff;
      wr_en = 1'b0; wr_addr = pos_ff[IndexWidth-1:0]; wr_data = hold_ff;
      rd_addr = pos_ff[IndexWidth-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data; phase_in = 1'b0;
               rsp_in = '0; rsp_in.entry_total = count_ff;
               state_in = S_DONE;
               unique case (req_data.operation)
                  OP_INSERT: begin
                     if (count_ff >= CountWidth'(Depth)) rsp_in.status = ST_FULL;
                     else begin pos_in = '0; state_in = S_SCAN; end
                  end
                  OP_DELETE, OP_READ: begin
                     if ({1'b0, req_data.index} >= count_ff)
                        rsp_in.status = ST_BAD_INDEX;
                     else begin
                        pos_in = {1'b0, req_data.index}; state_in = S_READ;
                     end
                  end
                  OP_FIND, OP_FIND_FIRST: begin
                     if (count_ff == '0) rsp_in.status = ST_NOT_FOUND;
                     else begin
                        first_in = '0; last_in = {1'b0, count_ff} - 1'b1;
                        state_in = S_SEARCH;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0; rsp_in.entry_total = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            // phase 0 issues read at pos, phase 1 checks it
            if (!phase_ff) begin
               if (pos_ff == count_ff) begin
                  // place found: shift from top down
                  hold_in = '{key: req_ff.key, payload: req_ff.payload};
                  rsp_in.found_index = pos_ff[IndexWidth-1:0];
                  rsp_in.found_key = req_ff.key;
                  rsp_in.found_payload = req_ff.payload;
                  first_in = {1'b0, count_ff};
                  state_in = S_SHIFT;
               end else phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (rd_data.key <= req_ff.key) pos_in = pos_ff + 1'b1;
               else begin
                  rsp_in.found_index = pos_ff[IndexWidth-1:0];
                  rsp_in.found_key = req_ff.key;
                  rsp_in.found_payload = req_ff.payload;
                  first_in = {1'b0, count_ff};
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            if (req_ff.operation == OP_INSERT) begin
               // first_ff is destination; read first-1 then write
               rd_addr = IndexWidth'(first_ff - 1'b1);
               if (first_ff == {1'b0, pos_ff}) begin
                  wr_en = 1'b1; wr_addr = pos_ff[IndexWidth-1:0];
                  wr_data = '{key: req_ff.key, payload: req_ff.payload};
                  count_in = count_ff + 1'b1;
                  rsp_in.entry_total = count_ff + 1'b1;
                  state_in = S_DONE;
               end else if (!phase_ff) phase_in = 1'b1;
               else begin
                  wr_en = 1'b1; wr_addr = IndexWidth'(first_ff);
                  wr_data = rd_data; phase_in = 1'b0;
                  first_in = first_ff - 1'b1;
               end
            end else begin
               // delete: destination first_ff, source first_ff+1
               rd_addr = IndexWidth'(first_ff + 1'b1);
               if (first_ff + 1'b1 >= {1'b0, count_ff}) begin
                  count_in = count_ff - 1'b1;
                  rsp_in.entry_total = count_ff - 1'b1;
                  state_in = S_DONE;
               end else if (!phase_ff) phase_in = 1'b1;
               else begin
                  wr_en = 1'b1; wr_addr = IndexWidth'(first_ff);
                  wr_data = rd_data; phase_in = 1'b0;
                  first_in = first_ff + 1'b1;
               end
            end
         end
         S_SEARCH: begin
            rd_addr = IndexWidth'(mid);
            if (!phase_ff) begin
               if ($signed(first_ff) > $signed(last_ff)) begin
                  rsp_in.status = ST_NOT_FOUND; state_in = S_DONE;
               end else phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (rd_data.key < req_ff.key) first_in = mid + 1'b1;
               else if (rd_data.key == req_ff.key) begin
                  pos_in = CountWidth'(mid); hold_in = rd_data;
                  state_in = (req_ff.operation == OP_FIND_FIRST) ? S_WALK : S_DONE;
                  rsp_in.found_index = IndexWidth'(mid);
                  rsp_in.found_key = rd_data.key;
                  rsp_in.found_payload = rd_data.payload;
               end else last_in = mid - 1'b1;
            end
         end
         S_WALK: begin
            rd_addr = IndexWidth'(pos_ff - 1'b1);
            if (!phase_ff) begin
               if (pos_ff == '0) state_in = S_DONE;
               else phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (rd_data.key == req_ff.key) begin
                  pos_in = pos_ff - 1'b1;
                  rsp_in.found_index = IndexWidth'(pos_ff - 1'b1);
                  rsp_in.found_payload = rd_data.payload;
               end else state_in = S_DONE;
            end
         end
         S_READ: begin
            if (!phase_ff) phase_in = 1'b1;
            else begin
               phase_in = 1'b0;
               rsp_in.found_index = pos_ff[IndexWidth-1:0];
               rsp_in.found_key = rd_data.key;
               rsp_in.found_payload = rd_data.payload;
               if (req_ff.operation == OP_DELETE) begin
                  first_in = {1'b0, pos_ff}; state_in = S_SHIFT;
               end else state_in = S_DONE;
            end
         end
         S_DONE: begin
            valid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; phase_ff <= 1'b0; count_ff <= '0; valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in; count_ff <= count_in;
         valid_ff <= valid_in;
      end
      req_ff <= req_in; pos_ff <= pos_in; first_ff <= first_in; last_ff <= last_in;
      rsp_ff <= rsp_in; hold_ff <= hold_in;
   end
endmodule

### tb/sorted_key_table_tb.sv
`timescale 1ns / 1ps
module sorted_key_table_tb;
   import skt_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   sorted_key_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // table model
   logic [31:0] model_keys [Depth];
   logic [31:0] model_pays [Depth];
   int unsigned model_count = 0;

   req_type pending_ops [$];
   rsp_type expected_rsps [$];
   int      error_count = 0;
   bit      stimulus_done = 1'b0;

   function automatic rsp_type table_apply(req_type r);
      rsp_type     o;
      int          first, last, mid, pos;
      bit          hit;
      o = '0;
      hit = 1'b0;
      pos = 0;
      case (r.operation)
         OP_INSERT: begin
            if (model_count >= Depth) begin
               o.status = ST_FULL;
            end else begin
               while (pos < model_count && model_keys[pos] <= r.key) pos++;
               for (int i = model_count; i > pos; i--) begin
                  model_keys[i] = model_keys[i-1];
                  model_pays[i] = model_pays[i-1];
               end
               model_keys[pos] = r.key;
               model_pays[pos] = r.payload;
               model_count++;
               o.found_index = pos[7:0];
               o.found_key = r.key;
               o.found_payload = r.payload;
            end
         end
         OP_DELETE: begin
            if (r.index >= model_count) begin
               o.status = ST_BAD_INDEX;
            end else begin
               o.found_index = r.index;
               o.found_key = model_keys[r.index];
               o.found_payload = model_pays[r.index];
               for (int i = r.index; i + 1 < model_count; i++) begin
                  model_keys[i] = model_keys[i+1];
                  model_pays[i] = model_pays[i+1];
               end
               model_count--;
            end
         end
         OP_FIND, OP_FIND_FIRST: begin
            first = 0;
            last = int'(model_count) - 1;
            while (!hit && first <= last) begin
               mid = (first + last) / 2;
               if (model_keys[mid] < r.key) first = mid + 1;
               else if (model_keys[mid] == r.key) begin
                  hit = 1'b1;
                  pos = mid;
               end else last = mid - 1;
            end
            if (!hit) begin
               o.status = ST_NOT_FOUND;
            end else begin
               if (r.operation == OP_FIND_FIRST)
                  while (pos > 0 && model_keys[pos-1] == r.key) pos--;
               o.found_index = pos[7:0];
               o.found_key = model_keys[pos];
               o.found_payload = model_pays[pos];
            end
         end
         OP_READ: begin
            if (r.index >= model_count) begin
               o.status = ST_BAD_INDEX;
            end else begin
               o.found_index = r.index;
               o.found_key = model_keys[r.index];
               o.found_payload = model_pays[r.index];
            end
         end
         OP_CLEAR: model_count = 0;
         default: ;
      endcase
      o.entry_total = model_count[8:0];
      return o;
   endfunction

   function automatic req_type make_op(logic [2:0] op, logic [31:0] key,
                                       logic [31:0] pay, logic [7:0] idx);
      req_type r;
      r.operation = op;
      r.key = key;
      r.payload = pay;
      r.index = idx;
      return r;
   endfunction

   // random key: modes 0 and 1 draw from narrow pools so finds hit and duplicates pile up; other modes draw any value
   function automatic logic [31:0] rand_key(int mode);
      case (mode)
         0: return $urandom_range(0, 15);
         1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   // driver
   int gap = 0;
   bit taken = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && taken) begin
         // transfer taken at the last rising edge
         start <= 1'b0;
         taken = 1'b0;
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      end else if (!start) begin
         if (gap > 0) begin
            gap--;
         end else if (pending_ops.size() > 0) begin
            req_data <= pending_ops.pop_front();
            start <= 1'b1;
         end
      end
   end

   // predictor fed at acceptance
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         expected_rsps.push_back(table_apply(req_data));
         taken = 1'b1;
      end
   end

   // monitor
   rsp_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status)
               $display("%0t: status exp %0d got %0d", $time, want.status,
                        rsp_data.status);
            if (rsp_data.found_index !== want.found_index)
               $display("%0t: found_index exp %0d got %0d", $time,
                        want.found_index, rsp_data.found_index);
            if (rsp_data.found_key !== want.found_key)
               $display("%0t: found_key exp %h got %h", $time, want.found_key,
                        rsp_data.found_key);
            if (rsp_data.found_payload !== want.found_payload)
               $display("%0t: found_payload exp %h got %h", $time,
                        want.found_payload, rsp_data.found_payload);
            if (rsp_data.entry_total !== want.entry_total)
               $display("%0t: entry_total exp %0d got %0d", $time,
                        want.entry_total, rsp_data.entry_total);
            if (rsp_data !== want) error_count++;
         end
      end
   end

   initial begin
      int          level, mode, r;
      logic [2:0]  op;
      // directed: empty table, extremes, duplicates, bad indexes, unused codes
      pending_ops.push_back(make_op(OP_READ, 0, 0, 0));
      pending_ops.push_back(make_op(OP_DELETE, 0, 0, 8'hFF));
      pending_ops.push_back(make_op(OP_FIND, 0, 0, 0));
      pending_ops.push_back(make_op(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
      pending_ops.push_back(make_op(OP_INSERT, 0, 0, 0));
      pending_ops.push_back(make_op(OP_INSERT, 7, 32'h1, 0));
      pending_ops.push_back(make_op(OP_INSERT, 7, 32'h2, 0));
      pending_ops.push_back(make_op(OP_INSERT, 7, 32'h3, 0));
      pending_ops.push_back(make_op(OP_FIND, 7, 0, 0));
      pending_ops.push_back(make_op(OP_FIND_FIRST, 7, 0, 0));
      pending_ops.push_back(make_op(OP_FIND_FIRST, 8, 0, 0));
      pending_ops.push_back(make_op(OP_FIND, 32'hFFFF_FFFF, 0, 0));
      pending_ops.push_back(make_op(OP_READ, 0, 0, 4));
      pending_ops.push_back(make_op(OP_READ, 0, 0, 5));
      pending_ops.push_back(make_op(OP_DELETE, 0, 0, 2));
      pending_ops.push_back(make_op(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
      pending_ops.push_back(make_op(3'd7, 0, 0, 0));
      pending_ops.push_back(make_op(OP_CLEAR, 0, 0, 0));
      pending_ops.push_back(make_op(OP_READ, 0, 0, 0));
      // fill to full once, then overflow
      for (int i = 0; i < Depth; i++)
         pending_ops.push_back(make_op(OP_INSERT, $urandom, $urandom, 0));
      pending_ops.push_back(make_op(OP_INSERT, 5, 5, 0));
      for (int i = 0; i < 8; i++)
         pending_ops.push_back(make_op(OP_FIND_FIRST, $urandom, 0, 0));
      pending_ops.push_back(make_op(OP_READ, 0, 0, 8'hFF));
      pending_ops.push_back(make_op(OP_DELETE, 0, 0, 8'hFF));
      pending_ops.push_back(make_op(OP_CLEAR, 0, 0, 0));
      // random: keep the table mostly small, steered around a target level
      level = 0;
      for (int n = 0; n < 1700; n++) begin
         mode = $urandom_range(0, 2);
         r = $urandom_range(0, 99);
         if (r < 35 + (level < 12 ? 15 : 0) - (level > 40 ? 25 : 0)) op = OP_INSERT;
         else if (r < 55) op = OP_DELETE;
         else if (r < 70) op = OP_FIND;
         else if (r < 85) op = OP_FIND_FIRST;
         else if (r < 97) op = OP_READ;
         else if (r < 99) op = OP_CLEAR;
         else op = 3'($urandom_range(6, 7));
         pending_ops.push_back(make_op(op, rand_key(mode), $urandom,
            $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, level))));
         if (op == OP_INSERT) level++;
         else if (op == OP_DELETE && level > 0) level--;
         else if (op == OP_CLEAR) level = 0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (pending_ops.size() == 0 && !start);
      wait (expected_rsps.size() == 0);
      repeat (600) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0)
         $display("** sorted_key_table: PASSED **");
      else
         $display("** sorted_key_table: FAILED **");
      $finish;
   end

   initial begin
      #100ms;
      $display("** sorted_key_table: FAILED **");
      $finish;
   end
endmodule
